@@ sv/bpv_pkg.sv @@
// Shared types and constants of the bit-packing varint encoder.
`timescale 1ns / 1ps

package bpv_pkg;

	localparam int VALUE_W = 64;
	localparam int ENC_W = 80;             // longest encoded field: ten varint bytes
	localparam int PEND_W = 7;             // bits held back between items
	localparam int WORK_W = ENC_W + PEND_W;
	localparam int LEN_W = 7;              // holds lengths up to WORK_W
	localparam int NB_W = 4;               // bytes per item, at most ten
	localparam int VAR_GROUPS = 10;
	localparam int VAR_DATA_W = 7;
	localparam int NIB_GROUPS = 20;
	localparam int NIB_DATA_W = 3;
	localparam int NIB_VALUE_W = 60;       // saturation limit is 2^60 - 1
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_BOOL   = 3'd0,
		OP_U32    = 3'd1,
		OP_U64    = 3'd2,
		OP_VARU   = 3'd3,
		OP_ZIGZAG = 3'd4,
		OP_NIBV   = 3'd5,
		OP_FLUSH  = 3'd6
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} back_state_t;

	typedef struct packed {
		logic             flush;
		logic [ENC_W-1:0] bits;
		logic [LEN_W-1:0] len;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic              busy;
		logic [2:0]        pcnt;
		logic [PEND_W-1:0] pend;
	} back_stat_t;

endpackage

@@ sv/bit_packing_varint_encoder.sv @@
// Top level of the LSB-first bit packer with LEB128-style and 4-bit-group varints.
// The single byte-shifting back end sets the pace: it merges each item with the pending bits,
// then sends that item's completed bytes (up to ten) one at a time; the queue hides the front.
// Reset clears the pending bits, the queue and all valid flags at once.
`timescale 1ns / 1ps

module bit_packing_varint_encoder #(
	parameter int QUEUE_DEPTH = bpv_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] value
	input  logic [2:0]  s_axis_tuser,   // [2:0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic        m_axis_tlast    // last_of_run
);

	logic                push;
	logic                pop;
	bpv_pkg::entry_t     push_entry;
	bpv_pkg::entry_t     head_entry;
	bpv_pkg::fifo_stat_t q_stat;
	bpv_pkg::back_stat_t bk_stat;

	bpv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_op      (s_axis_tuser),
		.in_value   (s_axis_tdata),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	bpv_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_entry),
		.pop    (pop),
		.rdata  (head_entry),
		.stat   (q_stat)
	);

	bpv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.rd        (head_entry),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.stat      (bk_stat)
	);

	// The front end never offers an item into a full queue.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("queue written while full");

	// Between items, bits above the pending count stay zero.
	a_pending_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!bk_stat.busy |-> ((bk_stat.pend >> bk_stat.pcnt) == '0))
		else $error("stray bits above the pending count");

	// A byte taken without tlast is followed by more bytes of the same run.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> bk_stat.busy || m_axis_tvalid)
		else $error("run ended without a last byte");

endmodule

@@ sv/bpv_front.sv @@
// Front end: accepts transactions, maps the value and builds the encoded bit string.
`timescale 1ns / 1ps

module bpv_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    in_op,
	input  logic [bpv_pkg::VALUE_W-1:0]   in_value,
	input  bpv_pkg::fifo_stat_t           q_stat,
	output logic                          push,
	output bpv_pkg::entry_t               push_entry
);

	logic                          keep;
	logic [bpv_pkg::VALUE_W-1:0]   load_val;
	logic                          valid_s1;
	bpv_pkg::op_t                  op_s1;
	logic [bpv_pkg::VALUE_W-1:0]   val_s1;

	logic [bpv_pkg::VAR_GROUPS*bpv_pkg::VAR_DATA_W-1:0] vx;
	logic [bpv_pkg::VAR_GROUPS-1:0]                     vcont;
	logic [bpv_pkg::NIB_GROUPS-1:0]                     ncont;
	logic [bpv_pkg::ENC_W-1:0]                          venc;
	logic [bpv_pkg::ENC_W-1:0]                          nenc;
	logic [3:0]                                         vcnt;
	logic [4:0]                                         ncnt;
	logic [bpv_pkg::LEN_W-1:0]                          vlen;
	logic [bpv_pkg::LEN_W-1:0]                          nlen;

	// Value mapping ahead of the stage register.
	always_comb begin
		load_val = '0;
		keep = 1'b1;
		case (bpv_pkg::op_t'(in_op))
			bpv_pkg::OP_BOOL:   load_val = {63'd0, |in_value};
			bpv_pkg::OP_U32:    load_val = {32'd0, in_value[31:0]};
			bpv_pkg::OP_U64:    load_val = in_value;
			bpv_pkg::OP_VARU:   load_val = in_value;
			bpv_pkg::OP_ZIGZAG: load_val = {in_value[62:0], 1'b0} ^ {64{in_value[63]}};
			bpv_pkg::OP_NIBV: begin
				if (|in_value[63:60]) begin
					load_val = {4'd0, {60{1'b1}}};
				end else begin
					load_val = in_value;
				end
			end
			bpv_pkg::OP_FLUSH:  load_val = '0;
			default:            keep = 1'b0;
		endcase
	end

	assign push = valid_s1 && !q_stat.full;
	assign in_ready = !valid_s1 || !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= bpv_pkg::op_t'(in_op);
			val_s1 <= load_val;
		end
	end

	// A group carries a continuation bit when any higher value bit is set; groups
	// past the last one are all zero, so the encodings need no masking.
	always_comb begin
		vx = {6'd0, val_s1};
		vcont = '0;
		ncont = '0;
		venc = '0;
		nenc = '0;
		for (int g = 0; g < bpv_pkg::VAR_GROUPS - 1; g++) begin
			vcont[g] = |(vx >> (bpv_pkg::VAR_DATA_W * (g + 1)));
		end
		for (int g = 0; g < bpv_pkg::NIB_GROUPS - 1; g++) begin
			ncont[g] = |(val_s1[bpv_pkg::NIB_VALUE_W-1:0] >> (bpv_pkg::NIB_DATA_W * (g + 1)));
		end
		for (int g = 0; g < bpv_pkg::VAR_GROUPS; g++) begin
			venc[8*g +: 8] = {vcont[g], vx[bpv_pkg::VAR_DATA_W*g +: bpv_pkg::VAR_DATA_W]};
		end
		for (int g = 0; g < bpv_pkg::NIB_GROUPS; g++) begin
			nenc[4*g +: 4] = {ncont[g], val_s1[bpv_pkg::NIB_DATA_W*g +: bpv_pkg::NIB_DATA_W]};
		end
		vcnt = 4'($countones(vcont));
		ncnt = 5'($countones(ncont));
		vlen = {vcnt + 4'd1, 3'd0};
		nlen = {ncnt + 5'd1, 2'd0};
	end

	always_comb begin
		push_entry.flush = 1'b0;
		push_entry.bits = '0;
		push_entry.len = '0;
		case (op_s1)
			bpv_pkg::OP_BOOL: begin
				push_entry.bits = {79'd0, val_s1[0]};
				push_entry.len = 7'd1;
			end
			bpv_pkg::OP_U32: begin
				push_entry.bits = {16'd0, val_s1};
				push_entry.len = 7'd32;
			end
			bpv_pkg::OP_U64: begin
				push_entry.bits = {16'd0, val_s1};
				push_entry.len = 7'd64;
			end
			bpv_pkg::OP_VARU, bpv_pkg::OP_ZIGZAG: begin
				push_entry.bits = venc;
				push_entry.len = vlen;
			end
			bpv_pkg::OP_NIBV: begin
				push_entry.bits = nenc;
				push_entry.len = nlen;
			end
			bpv_pkg::OP_FLUSH: push_entry.flush = 1'b1;
			default: push_entry.flush = 1'b0;
		endcase
	end

endmodule

@@ sv/bpv_fifo.sv @@
// Short queue of encoded fields between the front and back ends.
`timescale 1ns / 1ps

module bpv_fifo #(
	parameter int DEPTH = bpv_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bpv_pkg::entry_t     wdata,
	input  logic                pop,
	output bpv_pkg::entry_t     rdata,
	output bpv_pkg::fifo_stat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bpv_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]   wptr_q;
	logic [AW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign stat.full = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push = push && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

@@ sv/bpv_back.sv @@
// Back end: merges fields with the pending bits and sends completed bytes.
`timescale 1ns / 1ps

module bpv_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bpv_pkg::fifo_stat_t q_stat,
	input  bpv_pkg::entry_t     rd,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                out_last,
	output bpv_pkg::back_stat_t stat
);

	bpv_pkg::back_state_t          state_q;
	bpv_pkg::back_state_t          state_d;
	logic [bpv_pkg::WORK_W-1:0]    combined;
	logic [bpv_pkg::LEN_W-1:0]     total;
	logic [bpv_pkg::NB_W-1:0]      nb;
	logic [2:0]                    newcnt;
	logic                          fire;
	logic [bpv_pkg::WORK_W-1:0]    work_q;
	logic [bpv_pkg::NB_W-1:0]      left_q;
	logic [2:0]                    pcnt_q;
	logic [bpv_pkg::PEND_W-1:0]    pend_q;
	logic                          ovalid_q;
	logic [7:0]                    obyte_q;
	logic                          olast_q;

	always_comb begin
		combined = ({{bpv_pkg::PEND_W{1'b0}}, rd.bits} << pcnt_q)
			| {{bpv_pkg::ENC_W{1'b0}}, pend_q};
		total = rd.len + {4'd0, pcnt_q};
		if (rd.flush) begin
			nb = {3'd0, pcnt_q != 3'd0};
			newcnt = 3'd0;
		end else begin
			nb = total[6:3];
			newcnt = total[2:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bpv_pkg::ST_IDLE: begin
				if (!q_stat.empty && nb != '0) begin
					state_d = bpv_pkg::ST_EMIT;
				end
			end
			bpv_pkg::ST_EMIT: begin
				if (fire && left_q == 4'd1) begin
					state_d = bpv_pkg::ST_IDLE;
				end
			end
			default: state_d = bpv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		fire = 1'b0;
		case (state_q)
			bpv_pkg::ST_IDLE: pop = !q_stat.empty;
			bpv_pkg::ST_EMIT: fire = !ovalid_q || out_ready;
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpv_pkg::ST_IDLE;
			left_q <= '0;
			pcnt_q <= '0;
			pend_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				pcnt_q <= newcnt;
				left_q <= nb;
				// Items that finish no byte leave all their bits pending.
				if (nb == '0) begin
					pend_q <= combined[bpv_pkg::PEND_W-1:0];
				end
			end
			if (fire) begin
				left_q <= left_q - 1'b1;
				if (left_q == 4'd1) begin
					pend_q <= work_q[8 +: bpv_pkg::PEND_W];
				end
			end
			if (fire) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= combined;
		end else if (fire) begin
			work_q <= work_q >> 8;
		end
		if (fire) begin
			obyte_q <= work_q[7:0];
			olast_q <= (left_q == 4'd1);
		end
	end

	assign out_valid = ovalid_q;
	assign out_byte = obyte_q;
	assign out_last = olast_q;
	assign stat.busy = (state_q == bpv_pkg::ST_EMIT);
	assign stat.pcnt = pcnt_q;
	assign stat.pend = pend_q;

endmodule
